// ===== hw/rtl/cds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg
// Types, constants and calendar tables that the date stepper modules share.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DOY_W   = 9;
    localparam int STEP_FIELD_W = 16;
    localparam int CENT_W  = 7;   // century number, 0..99
    localparam int REM_W   = 7;   // year within century, 0..99

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_RESET = 14'd2000;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_DEC_LAST = 5'd31;

    // year / 100 as (year * CENT_RECIP) >> CENT_SHIFT, exact for all 14-bit years
    localparam int CENT_RECIP_W = 13;
    localparam logic [CENT_RECIP_W-1:0] CENT_RECIP = 13'd5243;
    localparam int CENT_SHIFT = 19;
    localparam int CENT_PROD_W = YEAR_W + CENT_RECIP_W;
    localparam logic [YEAR_W-1:0] CENT_SIZE = 14'd100;
    localparam logic [REM_W-1:0]  REM_LAST  = 7'd99;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_BACK = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_DIV,
        ST_LOAD_REM,
        ST_LOAD_DAY,
        ST_STEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;   // latch the incoming item
        logic load_div;  // saturate year, repair month, split out century
        logic load_rem;  // year within century
        logic load_day;  // repair day against the month length
        logic step;      // move the date one day
        logic publish;   // write the result register
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;  // no days left to step
        logic bound;     // next step would leave the year range
        logic out_free;  // result register can take a new result
    } t_dp_sts;

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the months before this one, common year
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
        logic [DOY_W-1:0] n;
        unique case (month)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/calendar_date_stepper_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_stepper_top
// Gregorian date register with load and day-by-day forward/backward stepping.
// ----------------------------------------------------------------------------
// The block holds one date (reset 01.01.2000) and returns one result per
// input transfer: the date, its day of year, a leap flag and a range error
// flag. Items are taken one at a time. On the way from the input transfer to
// the result register, a load passes the LOAD_DIV, LOAD_REM and LOAD_DAY
// states, a forward or backward step item moves one day per cycle in the day
// sequencer until step_count is used up or the year bound stops it, and mode 3
// goes straight to DONE. The next item is taken the cycle after the result is
// registered, even while that result still waits on the output side.
module calendar_date_stepper_top
    import cds_pkg::*;
#(
    parameter int STEP_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // in_day[4:0], in_month[8:5], in_year[22:9], step_count[38:23], zero[39]
    input  wire logic [39:0] s_axis_tdata,
    // mode[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_day[4:0], out_month[8:5], out_year[22:9], day_of_year[31:23]
    output logic [31:0]      m_axis_tdata,
    // is_leap[0], range_error[1]
    output logic [1:0]       m_axis_tuser
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    logic [DAY_W-1:0]   out_day;
    logic [MONTH_W-1:0] out_month;
    logic [YEAR_W-1:0]  out_year;
    logic [DOY_W-1:0]   out_doy;
    logic               out_leap;
    logic               out_err;

    cds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cds_dp #(
        .STEP_BITS (STEP_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (s_axis_tuser),
        .i_in_day      (s_axis_tdata[4:0]),
        .i_in_month    (s_axis_tdata[8:5]),
        .i_in_year     (s_axis_tdata[22:9]),
        .i_step_count  (s_axis_tdata[38:23]),
        .i_out_ready   (m_axis_tready),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .o_out_day     (out_day),
        .o_out_month   (out_month),
        .o_out_year    (out_year),
        .o_day_of_year (out_doy),
        .o_is_leap     (out_leap),
        .o_range_error (out_err)
    );

    assign m_axis_tdata = {out_doy, out_year, out_month, out_day};
    assign m_axis_tuser = {out_err, out_leap};

endmodule
`default_nettype wire

// ===== hw/rtl/cds_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cds_ctrl
// Sequencer for the date stepper: load, day stepping and result hand-off.
// ----------------------------------------------------------------------------
module cds_ctrl
    import cds_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_mode,
    output logic            o_in_ready,
    input  wire t_dp_sts    i_sts,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_LOAD) begin
                        n_state = ST_LOAD_DIV;
                    end else if (i_mode == MODE_FWD || i_mode == MODE_BACK) begin
                        n_state = ST_STEP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_LOAD_DIV: n_state = ST_LOAD_REM;
            ST_LOAD_REM: n_state = ST_LOAD_DAY;
            ST_LOAD_DAY: n_state = ST_DONE;
            ST_STEP: begin
                if (i_sts.cnt_zero || i_sts.bound) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_LOAD_DIV: o_cmd.load_div = 1'b1;
            ST_LOAD_REM: o_cmd.load_rem = 1'b1;
            ST_LOAD_DAY: o_cmd.load_day = 1'b1;
            ST_STEP:     o_cmd.step     = !i_sts.cnt_zero;
            ST_DONE:     o_cmd.publish  = i_sts.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/cds_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cds_dp
// Date registers, day step logic, load repair and the result register.
// ----------------------------------------------------------------------------
module cds_dp
    import cds_pkg::*;
#(
    parameter int STEP_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_dp_cmd                   i_cmd,
    input  wire logic [1:0]                i_mode,
    input  wire logic [DAY_W-1:0]          i_in_day,
    input  wire logic [MONTH_W-1:0]        i_in_month,
    input  wire logic [YEAR_W-1:0]         i_in_year,
    input  wire logic [STEP_FIELD_W-1:0]   i_step_count,
    input  wire logic                      i_out_ready,
    output t_dp_sts                        o_sts,
    output logic                           o_out_valid,
    output logic [DAY_W-1:0]               o_out_day,
    output logic [MONTH_W-1:0]             o_out_month,
    output logic [YEAR_W-1:0]              o_out_year,
    output logic [DOY_W-1:0]               o_day_of_year,
    output logic                           o_is_leap,
    output logic                           o_range_error
);

    localparam int CNT_W = (STEP_BITS < STEP_FIELD_W) ? STEP_BITS : STEP_FIELD_W;

    // current date; century and year-within-century track the year for the leap rule
    logic [DAY_W-1:0]   r_day;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;
    logic [CENT_W-1:0]  r_cent;
    logic [REM_W-1:0]   r_rem;
    logic               r_err;

    logic [DAY_W-1:0]   r_ld_day;
    logic [MONTH_W-1:0] r_ld_month;
    logic [YEAR_W-1:0]  r_ld_year;
    logic               r_fwd;
    logic [CNT_W-1:0]   r_cnt;

    logic               r_out_valid;
    logic [DAY_W-1:0]   r_out_day;
    logic [MONTH_W-1:0] r_out_month;
    logic [YEAR_W-1:0]  r_out_year;
    logic [DOY_W-1:0]   r_out_doy;
    logic               r_out_leap;
    logic               r_out_err;

    logic                   leap;
    logic [DAY_W-1:0]       month_len;
    logic                   month_end;
    logic                   fwd_bound;
    logic                   back_bound;
    logic [YEAR_W-1:0]      sat_year;
    logic [CENT_PROD_W-1:0] cent_prod;
    logic [YEAR_W-1:0]      rem_full;
    logic [DAY_W-1:0]       prev_len;
    logic [DOY_W-1:0]       doy;

    assign leap = (r_rem[1:0] == 2'd0) && ((r_rem != '0) || (r_cent[1:0] == 2'd0));
    assign month_len = days_in(r_month, leap);
    assign month_end = (r_day >= month_len);
    assign fwd_bound  = month_end && (r_month == MONTH_DEC) && (r_year >= YEAR_MAX);
    assign back_bound = (r_day == DAY_FIRST) && (r_month == MONTH_JAN) && (r_year == '0);
    assign prev_len   = days_in(r_month - MONTH_W'(1), leap);

    assign sat_year  = (r_ld_year > YEAR_MAX) ? YEAR_MAX : r_ld_year;
    assign cent_prod = CENT_PROD_W'(sat_year) * CENT_PROD_W'(CENT_RECIP);
    assign rem_full  = r_year - YEAR_W'(r_cent) * CENT_SIZE;

    assign doy = days_before(r_month) + DOY_W'(r_day)
               + DOY_W'(leap && (r_month > MONTH_FEB));

    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.bound    = r_fwd ? fwd_bound : back_bound;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= DAY_FIRST;
            r_month <= MONTH_JAN;
            r_year  <= YEAR_RESET;
            r_cent  <= CENT_W'(YEAR_RESET / 100);
            r_rem   <= '0;
            r_err   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_err <= 1'b0;
                r_cnt <= i_step_count[CNT_W-1:0];
            end
            if (i_cmd.load_div) begin
                r_year  <= sat_year;
                r_cent  <= cent_prod[CENT_SHIFT +: CENT_W];
                r_month <= (r_ld_month == '0 || r_ld_month > MONTH_DEC) ? MONTH_JAN
                                                                        : r_ld_month;
            end
            if (i_cmd.load_rem) begin
                r_rem <= rem_full[REM_W-1:0];
            end
            if (i_cmd.load_day) begin
                r_day <= (r_ld_day == '0 || r_ld_day > month_len) ? DAY_FIRST : r_ld_day;
            end
            if (i_cmd.step) begin
                if (o_sts.bound) begin
                    // hold the date, drop the remaining steps
                    r_err <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_fwd) begin
                        if (!month_end) begin
                            r_day <= r_day + DAY_W'(1);
                        end else if (r_month != MONTH_DEC) begin
                            r_day   <= DAY_FIRST;
                            r_month <= r_month + MONTH_W'(1);
                        end else begin
                            r_day   <= DAY_FIRST;
                            r_month <= MONTH_JAN;
                            r_year  <= r_year + YEAR_W'(1);
                            if (r_rem == REM_LAST) begin
                                r_rem  <= '0;
                                r_cent <= r_cent + CENT_W'(1);
                            end else begin
                                r_rem <= r_rem + REM_W'(1);
                            end
                        end
                    end else begin
                        if (r_day != DAY_FIRST) begin
                            r_day <= r_day - DAY_W'(1);
                        end else if (r_month != MONTH_JAN) begin
                            r_month <= r_month - MONTH_W'(1);
                            r_day   <= prev_len;
                        end else begin
                            r_month <= MONTH_DEC;
                            r_day   <= DAY_DEC_LAST;
                            r_year  <= r_year - YEAR_W'(1);
                            if (r_rem == '0) begin
                                r_rem  <= REM_LAST;
                                r_cent <= r_cent - CENT_W'(1);
                            end else begin
                                r_rem <= r_rem - REM_W'(1);
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ld_day   <= i_in_day;
            r_ld_month <= i_in_month;
            r_ld_year  <= i_in_year;
            r_fwd      <= (i_mode == MODE_FWD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_day   <= r_day;
            r_out_month <= r_month;
            r_out_year  <= r_year;
            r_out_doy   <= doy;
            r_out_leap  <= leap;
            r_out_err   <= r_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_day     = r_out_day;
    assign o_out_month   = r_out_month;
    assign o_out_year    = r_out_year;
    assign o_day_of_year = r_out_doy;
    assign o_is_leap     = r_out_leap;
    assign o_range_error = r_out_err;

endmodule
`default_nettype wire

// ===== dv/calendar_date_stepper_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_stepper_top_tb
// Self-checking bench for the Gregorian date stepper.
// ----------------------------------------------------------------------------
// A directed part covers load repair, leap rules, month and year rollover,
// the year bounds, zero steps and the unused mode. Random items follow under
// several idle and stall patterns, including one long output hold-off. A
// scoreboard class keeps its own date and predicts every result.
module calendar_date_stepper_top_tb;
    import cds_pkg::*;

    localparam int          CLK_HALF          = 6;
    localparam int          WATCHDOG_LIMIT    = 300_000;
    localparam int          DRAIN_CYCLES      = 20;
    localparam int          LONG_HOLD_CYCLES  = 400;
    localparam int          ITEMS_PER_PHASE   = 20;
    localparam int          PRESSURE_ITEMS    = 10;
    localparam logic [1:0]  MODE_HOLD         = 2'd3;

    typedef struct packed {
        logic [1:0]              mode;
        logic [DAY_W-1:0]        day;
        logic [MONTH_W-1:0]      month;
        logic [YEAR_W-1:0]       year;
        logic [STEP_FIELD_W-1:0] steps;
    } t_date_item;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [DOY_W-1:0]   doy;
        logic               leap;
        logic               range_err;
    } t_date_result;

    class date_scoreboard;
        t_date_result expected_q[$];
        int unsigned  fail_count;
        int unsigned  held_day;
        int unsigned  held_month;
        int unsigned  held_year;

        function new();
            held_day   = 1;
            held_month = 1;
            held_year  = 32'(YEAR_RESET);
            fail_count = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function int unsigned month_days(int unsigned m, int unsigned y);
            if (m == 2) return leap_year(y) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
            return 31;
        endfunction

        // leave the date untouched when the year would pass 9999
        function bit advance_day();
            if (held_day < month_days(held_month, held_year)) begin
                held_day++;
                return 1'b1;
            end
            if (held_month < 12) begin
                held_month++;
                held_day = 1;
                return 1'b1;
            end
            if (held_year >= YEAR_MAX) return 1'b0;
            held_year++;
            held_month = 1;
            held_day   = 1;
            return 1'b1;
        endfunction

        function bit retreat_day();
            if (held_day > 1) begin
                held_day--;
                return 1'b1;
            end
            if (held_month > 1) begin
                held_month--;
            end else begin
                if (held_year == 0) return 1'b0;
                held_month = 12;
                held_year--;
            end
            held_day = month_days(held_month, held_year);
            return 1'b1;
        endfunction

        function int unsigned day_number();
            int unsigned n;
            n = held_day;
            for (int unsigned m = 1; m < held_month; m++) n += month_days(m, held_year);
            return n;
        endfunction

        function void note_item(t_date_item it);
            t_date_result r;
            bit           hit_bound;
            int unsigned  y;
            int unsigned  m;
            int unsigned  d;
            hit_bound = 1'b0;
            case (it.mode)
                MODE_LOAD: begin
                    y = 32'((it.year > YEAR_MAX) ? YEAR_MAX : it.year);
                    m = (it.month < 1 || it.month > 12) ? 1 : 32'(it.month);
                    d = (it.day < 1 || it.day > month_days(m, y)) ? 1 : 32'(it.day);
                    held_day   = d;
                    held_month = m;
                    held_year  = y;
                end
                MODE_FWD, MODE_BACK: begin
                    for (int unsigned n = 0; n < it.steps; n++) begin
                        if (!((it.mode == MODE_FWD) ? advance_day() : retreat_day())) begin
                            hit_bound = 1'b1;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            r.day       = DAY_W'(held_day);
            r.month     = MONTH_W'(held_month);
            r.year      = YEAR_W'(held_year);
            r.doy       = DOY_W'(day_number());
            r.leap      = leap_year(held_year);
            r.range_err = hit_bound;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(logic [31:0] data, logic [1:0] flags);
            t_date_result want;
            if (expected_q.size() == 0) begin
                $error("result with no pending item: tdata %h tuser %b", data, flags);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_day",     32'(want.day),       32'(data[4:0]));
            compare_field("out_month",   32'(want.month),     32'(data[8:5]));
            compare_field("out_year",    32'(want.year),      32'(data[22:9]));
            compare_field("day_of_year", 32'(want.doy),       32'(data[31:23]));
            compare_field("is_leap",     32'(want.leap),      32'(flags[0]));
            compare_field("range_error", 32'(want.range_err), 32'(flags[1]));
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // in_day[4:0], in_month[8:5], in_year[22:9], step_count[38:23], zero[39]
    logic [39:0] s_axis_tdata  = '0;
    // mode[1:0]
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_day[4:0], out_month[8:5], out_year[22:9], day_of_year[31:23]
    logic [31:0] m_axis_tdata;
    // is_leap[0], range_error[1]
    logic [1:0]  m_axis_tuser;

    int unsigned    tx_idle_pct   = 0;
    int unsigned    rx_stall_pct  = 0;
    bit             long_hold_req = 1'b0;
    int unsigned    quiet_cycles  = 0;
    date_scoreboard sb            = new();

    calendar_date_stepper_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // watch both sides at the edge and predict or check each transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item({s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[8:5],
                              s_axis_tdata[22:9], s_axis_tdata[38:23]});
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata, m_axis_tuser);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req <= 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
            @(posedge i_clk);
        end
    end

    task automatic send_item(input t_date_item it);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, it.steps, it.year, it.month, it.day};
        s_axis_tuser  <= it.mode;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_fields(input logic [1:0] mode, input int unsigned d,
                               input int unsigned m, input int unsigned y,
                               input int unsigned n);
        send_item({mode, DAY_W'(d), MONTH_W'(m), YEAR_W'(y), STEP_FIELD_W'(n)});
    endtask

    function automatic t_date_item random_date_item(input int unsigned max_small_step);
        t_date_item  it;
        int unsigned pick;
        it.day   = DAY_W'($urandom_range(0, 31));
        it.month = MONTH_W'($urandom_range(0, 15));
        it.year  = YEAR_W'($urandom_range(0, 16383));
        it.steps = STEP_FIELD_W'($urandom_range(0, 65535));
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            it.mode = MODE_HOLD;
        end else if (pick < 34) begin
            it.mode = MODE_LOAD;
            pick = $urandom_range(0, 99);
            // bias loads toward the year bounds so stepping runs into them
            if (pick < 10)      it.year = YEAR_W'($urandom_range(0, 3));
            else if (pick < 20) it.year = YEAR_W'($urandom_range(9995, 9999));
            else if (pick < 85) it.year = YEAR_W'($urandom_range(0, 9999));
            if ($urandom_range(0, 99) < 85) it.month = MONTH_W'($urandom_range(1, 12));
            if ($urandom_range(0, 99) < 70) it.day = DAY_W'($urandom_range(1, 28));
        end else begin
            it.mode = (pick < 67) ? MODE_FWD : MODE_BACK;
            pick = $urandom_range(0, 99);
            if (pick >= 3) begin
                it.steps = (pick < 15) ? STEP_FIELD_W'($urandom_range(0, 2000))
                                       : STEP_FIELD_W'($urandom_range(0, max_small_step));
            end
        end
        return it;
    endfunction

    initial begin
        int unsigned idle_plan[4]  = '{0, 57, 0, 20};
        int unsigned stall_plan[4] = '{0, 0, 57, 20};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset date, load repair, leap rules, rollover, bounds
        send_fields(MODE_HOLD, 0,  0,  0,     0);
        send_fields(MODE_LOAD, 29, 2,  2000,  0);
        send_fields(MODE_LOAD, 29, 2,  1900,  0);
        send_fields(MODE_LOAD, 29, 2,  2100,  0);
        send_fields(MODE_LOAD, 31, 4,  2023,  0);
        send_fields(MODE_LOAD, 0,  0,  0,     0);
        send_fields(MODE_LOAD, 31, 15, 16383, 65535);
        send_fields(MODE_LOAD, 15, 13, 1987,  0);
        send_fields(MODE_LOAD, 31, 12, 2023,  0);
        send_fields(MODE_FWD,  0,  0,  0,     1);
        send_fields(MODE_BACK, 0,  0,  0,     1);
        send_fields(MODE_FWD,  31, 15, 16383, 0);
        send_fields(MODE_BACK, 31, 15, 16383, 0);
        send_fields(MODE_LOAD, 28, 2,  2024,  0);
        send_fields(MODE_FWD,  0,  0,  0,     2);
        send_fields(MODE_LOAD, 1,  3,  2000,  0);
        send_fields(MODE_BACK, 0,  0,  0,     1);
        send_fields(MODE_LOAD, 25, 12, 9999,  0);
        send_fields(MODE_FWD,  0,  0,  0,     10);
        send_fields(MODE_FWD,  0,  0,  0,     1);
        send_fields(MODE_LOAD, 5,  1,  0,     0);
        send_fields(MODE_BACK, 0,  0,  0,     10);
        send_fields(MODE_BACK, 0,  0,  0,     1);
        send_fields(MODE_LOAD, 1,  1,  5000,  0);
        send_fields(MODE_FWD,  0,  0,  0,     65535);
        send_fields(MODE_BACK, 0,  0,  0,     65535);
        send_fields(MODE_HOLD, 31, 15, 16383, 65535);

        // hold the output off so the block fills up and stalls its input
        long_hold_req <= 1'b1;
        repeat (PRESSURE_ITEMS) send_item(random_date_item(20));

        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = idle_plan[p];
            rx_stall_pct = stall_plan[p];
            repeat (ITEMS_PER_PHASE) send_item(random_date_item(60));
        end
        s_axis_tvalid <= 1'b0;
        // let the monitor note the last transfer before counting pending results
        @(posedge i_clk);

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.fail_count++;
        end
        if (sb.fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
